FILE: rtl/core/aes_pkg.sv
package aes_pkg;

    localparam int KEY_WORDS_DEF   = 4;
    localparam int ROUND_COUNT_DEF = 10;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_RUN
    } ks_state_t;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] block_t;

    function automatic byte_t xt(input byte_t a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t p;
        byte_t x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p = p ^ x;
            end
            x = xt(x);
        end
        gf_mul = p;
    endfunction

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Byte n of the state sits at bits 127-8n.
    function automatic byte_t get_byte(input block_t s, input int n);
        get_byte = s[127 - 8 * n -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t s, input logic inverse);
        block_t t;
        byte_t b;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inverse) begin
                    b = INV_SBOX[get_byte(s, r + 4 * ((c + 4 - r) % 4))];
                end else begin
                    b = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
                end
                t[127 - 8 * (r + 4 * c) -: 8] = b;
            end
        end
        sub_shift = t;
    endfunction

    function automatic block_t mix_cols(input block_t s, input logic inverse);
        block_t t;
        byte_t acc;
        byte_t m [4];
        if (inverse) begin
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++) begin
                    acc = acc ^ gf_mul(m[(j - r + 4) % 4], get_byte(s, 4 * c + j));
                end
                t[127 - 8 * (4 * c + r) -: 8] = acc;
            end
        end
        mix_cols = t;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

FILE: rtl/core/aes128_block_cipher_unit.sv
// AES-128 encrypt/decrypt unit.
// Configuration: write key_high (index 0) and key_low (index 1) through
// cfg_we/cfg_index/cfg_data while the unit is idle. Any key write marks the
// round keys stale; the next start then runs a key expansion (round key 0
// loaded, then one round key a cycle) during which busy is high.
// Data: a block beat is taken when start is high and busy is low, with
// operation (0 encrypt, 1 decrypt), block_high and block_low.
// Datapath: an initial key addition stage and ten round stages, one
// register each, so a new block can enter every cycle once keys are ready.
// A beat passes the stage 0 register and the ten round registers to done; the
// rate is one block per cycle, each stage one round (S-box, mix cols, key add).
// Results: result_high/result_low are valid for exactly one cycle with done;
// the receiver cannot stall, so the pipeline never holds.
// Reset: clears all valid bits and marks keys as not expanded; the round
// key store itself is undefined until the first expansion.
module aes128_block_cipher_unit #(
    parameter int KEY_WORDS   = aes_pkg::KEY_WORDS_DEF,
    parameter int ROUND_COUNT = aes_pkg::ROUND_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        done,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import aes_pkg::*;

    localparam int NK = ROUND_COUNT + 1;
    localparam int RW = $clog2(NK + 1);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        keys_ready_reg;
    logic        keys_ready_next;
    ks_state_t   ks_state_reg;
    ks_state_t   ks_state_next;
    logic [RW-1:0] ks_cnt_reg;
    logic [RW-1:0] ks_cnt_next;
    logic [127:0]  ks_word_reg;
    logic [127:0]  ks_word_next;
    logic [7:0]    rcon_reg;
    logic [7:0]    rcon_next;
    logic          ks_load;
    logic          ks_write;
    logic [127:0]  exp_key;

    // Round keys live in registers; each stage picks its key by direction.
    block_t rk_reg [NK];

    logic   accept;
    logic   s0_valid_reg;
    logic   s0_dec_reg;
    block_t s0_state_reg;

    logic   v    [NK];
    logic   d    [NK];
    block_t st   [NK];

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) begin
                key_high_reg <= cfg_data;
            end else begin
                key_low_reg <= cfg_data;
            end
        end
    end

    // ---------------- key expansion sequencer ----------------
    always_comb
    begin
        logic [31:0] w0, w1, w2, w3, t;
        w0 = ks_word_reg[127:96];
        w1 = ks_word_reg[95:64];
        w2 = ks_word_reg[63:32];
        w3 = ks_word_reg[31:0];
        t  = sbox_word({w3[23:0], w3[31:24]}) ^ {rcon_reg, 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        exp_key = {w0, w1, w2, w3};
    end

    always_comb
    begin
        ks_state_next   = ks_state_reg;
        ks_cnt_next     = ks_cnt_reg;
        ks_word_next    = ks_word_reg;
        rcon_next       = rcon_reg;
        keys_ready_next = keys_ready_reg;
        ks_load         = 1'b0;
        ks_write        = 1'b0;
        case (ks_state_reg)
            KS_IDLE:
            begin
                if (start && !keys_ready_reg) begin
                    // Round key 0 is the cipher key itself.
                    ks_load       = 1'b1;
                    ks_word_next  = {key_high_reg, key_low_reg};
                    ks_cnt_next   = RW'(1);
                    rcon_next     = 8'h01;
                    ks_state_next = KS_RUN;
                end
            end
            KS_RUN:
            begin
                ks_write     = 1'b1;
                ks_word_next = exp_key;
                rcon_next    = xt(rcon_reg);
                ks_cnt_next  = ks_cnt_reg + RW'(1);
                if (ks_cnt_reg == RW'(ROUND_COUNT)) begin
                    keys_ready_next = 1'b1;
                    ks_state_next   = KS_IDLE;
                end
            end
            default:
            begin
                ks_state_next = KS_IDLE;
            end
        endcase
        if (cfg_we) begin
            keys_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ks_state_reg   <= KS_IDLE;
            keys_ready_reg <= 1'b0;
            ks_cnt_reg     <= '0;
        end else begin
            ks_state_reg   <= ks_state_next;
            keys_ready_reg <= keys_ready_next;
            ks_cnt_reg     <= ks_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ks_word_reg <= ks_word_next;
        rcon_reg    <= rcon_next;
        if (ks_load) begin
            rk_reg[0] <= {key_high_reg, key_low_reg};
        end
        for (int i = 1; i < NK; i++) begin
            if (ks_write && ks_cnt_reg == RW'(i)) begin
                rk_reg[i] <= exp_key;
            end
        end
    end

    // ---------------- pipeline ----------------
    assign busy   = !keys_ready_reg || ks_state_reg != KS_IDLE;
    assign accept = start && !busy;

    // Stage 0: initial key addition (round key 0 for encrypt, last for decrypt).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
        end else begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_dec_reg   <= operation;
        s0_state_reg <= {block_high, block_low} ^
                        (operation ? rk_reg[ROUND_COUNT] : rk_reg[0]);
    end

    assign v[0]  = s0_valid_reg;
    assign d[0]  = s0_dec_reg;
    assign st[0] = s0_state_reg;

    // Stage r applies round r (encrypt) or uses key ROUND_COUNT-r (decrypt).
    for (genvar r = 1; r < NK; r++) begin : g_round
        aes_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[r-1]),
            .in_dec    (d[r-1]),
            .last      (r == ROUND_COUNT),
            .state     (st[r-1]),
            .rkey      (d[r-1] ? rk_reg[ROUND_COUNT - r] : rk_reg[r]),
            .out_valid (v[r]),
            .out_dec   (d[r]),
            .out_state (st[r])
        );
    end

    assign done        = v[ROUND_COUNT];
    assign result_high = st[ROUND_COUNT][127:64];
    assign result_low  = st[ROUND_COUNT][63:0];

endmodule

FILE: rtl/core/aes_round.sv
module aes_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_dec,
    input  logic              last,
    input  aes_pkg::block_t   state,
    input  aes_pkg::block_t   rkey,
    output logic              out_valid,
    output logic              out_dec,
    output aes_pkg::block_t   out_state
);
    import aes_pkg::*;

    block_t sub_next;
    block_t next_state;

    // Sub/shift; enc: mix, add key; dec: add key, inv mix; last: key only.
    always_comb
    begin
        sub_next = sub_shift(state, in_dec);
        if (last) begin
            next_state = sub_next ^ rkey;
        end else if (in_dec) begin
            next_state = mix_cols(sub_next ^ rkey, 1'b1);
        end else begin
            next_state = mix_cols(sub_next, 1'b0) ^ rkey;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid <= 1'b0;
        end else begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dec   <= in_dec;
        out_state <= next_state;
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;

    // AES-128 golden model: owns its copy of the key, the round key
    // schedule and the queue of blocks the unit still owes us.
    class aes_scoreboard;
        logic [7:0]   fwd_sub [256];
        logic [7:0]   rev_sub [256];
        logic [127:0] rkeys [11];
        logic [127:0] owed_blocks [$];
        int           errors;

        function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
            logic [7:0] p;
            p = 8'h00;
            for (int i = 0; i < 8; i++)
            begin
                if (b[i])
                    p = p ^ a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return p;
        endfunction

        function void build_tables();
            logic [7:0] iv;
            logic [7:0] pw;
            logic [7:0] sv;
            for (int x = 0; x < 256; x++)
            begin
                // x^254 is the field inverse, and maps zero to zero
                iv = 8'h01;
                pw = x[7:0];
                for (int e = 0; e < 8; e++)
                begin
                    if (e != 0)
                        iv = gmul(iv, pw);
                    pw = gmul(pw, pw);
                end
                sv = iv ^ {iv[6:0], iv[7]} ^ {iv[5:0], iv[7:6]} ^ {iv[4:0], iv[7:5]}
                     ^ {iv[3:0], iv[7:4]} ^ 8'h63;
                fwd_sub[x] = sv;
                rev_sub[sv] = x[7:0];
            end
        endfunction

        function new();
            errors = 0;
            build_tables();
            set_key(64'h0, 64'h0);
        endfunction

        function void set_key(logic [63:0] hi, logic [63:0] lo);
            logic [31:0] w [44];
            logic [31:0] t;
            logic [7:0]  rcon;
            rcon = 8'h01;
            {w[0], w[1], w[2], w[3]} = {hi, lo};
            for (int i = 4; i < 44; i++)
            begin
                t = w[i - 1];
                if (i % 4 == 0)
                begin
                    t = {t[23:0], t[31:24]};
                    t = {fwd_sub[t[31:24]] ^ rcon, fwd_sub[t[23:16]],
                         fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
                    rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
                end
                w[i] = w[i - 4] ^ t;
            end
            for (int r = 0; r < 11; r++)
                rkeys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        endfunction

        // byte n of the state lives at bits 127-8n; column n/4, row n%4
        function logic [127:0] sub_and_shift(logic [127:0] s, bit inv);
            logic [127:0] t;
            logic [7:0]   v;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                begin
                    if (inv)
                    begin
                        v = s[127 - 8 * (r + 4 * c) -: 8];
                        t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = rev_sub[v];
                    end
                    else
                    begin
                        v = s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8];
                        t[127 - 8 * (r + 4 * c) -: 8] = fwd_sub[v];
                    end
                end
            return t;
        endfunction

        function logic [127:0] mix(logic [127:0] s, bit inv);
            logic [7:0]   cf [4];
            logic [7:0]   acc;
            logic [127:0] t;
            if (inv)
                cf = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            else
                cf = '{8'h02, 8'h03, 8'h01, 8'h01};
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                begin
                    acc = 8'h00;
                    for (int j = 0; j < 4; j++)
                        acc = acc ^ gmul(cf[(j - r + 4) % 4], s[127 - 8 * (4 * c + j) -: 8]);
                    t[127 - 8 * (4 * c + r) -: 8] = acc;
                end
            return t;
        endfunction

        // note one accepted input beat and queue the block it must produce
        function void note_block(bit decrypt, logic [63:0] hi, logic [63:0] lo);
            logic [127:0] s;
            s = {hi, lo};
            if (!decrypt)
            begin
                s = s ^ rkeys[0];
                for (int r = 1; r < 10; r++)
                    s = mix(sub_and_shift(s, 0), 0) ^ rkeys[r];
                s = sub_and_shift(s, 0) ^ rkeys[10];
            end
            else
            begin
                s = s ^ rkeys[10];
                for (int r = 9; r > 0; r--)
                    s = mix(sub_and_shift(s, 1) ^ rkeys[r], 1);
                s = sub_and_shift(s, 1) ^ rkeys[0];
            end
            owed_blocks.push_back(s);
        endfunction

        function void check_block(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] want;
            if (owed_blocks.size() == 0)
            begin
                $error("result beat %h_%h with nothing outstanding", hi, lo);
                errors++;
                return;
            end
            want = owed_blocks.pop_front();
            if (hi !== want[127:64])
            begin
                $error("result_high: expected %h, got %h", want[127:64], hi);
                errors++;
            end
            if (lo !== want[63:0])
            begin
                $error("result_low: expected %h, got %h", want[63:0], lo);
                errors++;
            end
        endfunction
    endclass

    localparam logic KEY_HIGH_IDX = 1'b0;
    localparam logic KEY_LOW_IDX  = 1'b1;
    localparam logic OP_ENCRYPT   = 1'b0;
    localparam logic OP_DECRYPT   = 1'b1;
    localparam int   STALL_LIMIT  = 2000;
    localparam int   DRAIN_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        done;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    aes_scoreboard sb;
    int            idle_cycles = 0;

    aes128_block_cipher_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .block_high  (block_high),
        .block_low   (block_low),
        .done        (done),
        .result_high (result_high),
        .result_low  (result_low),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sample both sides at the edge; driven inputs and the unit's
    // registers still hold their pre-edge values here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
                sb.note_block(operation, block_high, block_low);
            if (done)
                sb.check_block(result_high, result_low);
        end
    end

    // Watchdog: drop out if nothing moves for too long.
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("aes128_block_cipher_unit: mismatch");
            $finish;
        end
    end

    // Hold one block beat on the ports until the unit takes it. Start stays
    // high on return, so a burst runs on without a bubble.
    task automatic send_block(logic op, logic [63:0] hi, logic [63:0] lo);
        logic was_busy;
        start      <= 1'b1;
        operation  <= op;
        block_high <= hi;
        block_low  <= lo;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
    endtask

    // End a burst: lower start and idle for the given number of cycles.
    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Wait until every owed block is back, then for DRAIN_CYCLES more, so a
    // key write never lands while the unit is working.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.owed_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        cfg_we    <= 1'b1;
        cfg_index <= KEY_HIGH_IDX;
        cfg_data  <= hi;
        @(posedge clk);
        sb.set_key(hi, lo);
        cfg_index <= KEY_LOW_IDX;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_blocks(int count);
        int burst;
        int gap;
        burst = $urandom_range(1, 20);
        for (int i = 0; i < count; i++)
        begin
            send_block($urandom_range(0, 1), rand64(), rand64());
            burst--;
            if (burst == 0)
            begin
                // a zero-length gap lets the next burst follow with no bubble
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0)
                    pause_sender(gap);
                burst = $urandom_range(1, 20);
            end
        end
    endtask

    initial
    begin
        logic [63:0] kh;
        logic [63:0] kl;
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = OP_ENCRYPT;
        block_high  = '0;
        block_low   = '0;
        cfg_we      = 1'b0;
        cfg_index   = KEY_HIGH_IDX;
        cfg_data    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key is all zeros: run on it without any write first.
        send_block(OP_ENCRYPT, 64'h0, 64'h0);
        send_block(OP_DECRYPT, 64'h0, 64'h0);
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, '1, '1);
        wait_idle();

        // Standard example key and plaintext, both directions.
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        pause_sender(3);
        send_block(OP_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_block(OP_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        wait_idle();

        // Rewrite the same key: the schedule must re-expand and still match.
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        wait_idle();

        // All-ones key, extremes of the block.
        load_key('1, '1);
        send_block(OP_ENCRYPT, 64'h0, 64'h0);
        send_block(OP_DECRYPT, '1, '1);
        send_block(OP_ENCRYPT, '1, 64'h0);
        send_block(OP_DECRYPT, 64'h0, '1);
        wait_idle();

        // Random phases, each behind a fresh key; the first and last phases
        // sit on the extreme keys.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
                load_key('0, '0);
            else if (ph == 7)
                load_key('1, '1);
            else
                load_key(rand64(), rand64());
            random_blocks(ph == 7 ? 130 : 196);
            wait_idle();
            if (ph == 3)
            begin
                // drop a single register write between phases too
                kh = rand64();
                cfg_we    <= 1'b1;
                cfg_index <= KEY_HIGH_IDX;
                cfg_data  <= kh;
                @(posedge clk);
                cfg_we <= 1'b0;
                kl = sb.rkeys[0][63:0];
                sb.set_key(kh, kl);
                @(posedge clk);
                random_blocks(20);
                wait_idle();
            end
        end

        if (sb.errors == 0 && sb.owed_blocks.size() == 0)
            $display("aes128_block_cipher_unit: match");
        else
            $display("aes128_block_cipher_unit: mismatch");
        $finish;
    end

endmodule
